### sv/target_bearing_and_range_core_defines.svh
// Assertion macros for the target bearing and range core
`ifndef TARGET_BEARING_AND_RANGE_CORE_DEFINES_SVH
`define TARGET_BEARING_AND_RANGE_CORE_DEFINES_SVH
`ifndef SYNTH
`define TBR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("tbr assertion failed");
`define TBR_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
      else $error("tbr implication failed");
`else
`define TBR_ASSERT(label, clk, rst, prop)
`define TBR_ASSERT_IMPLY(label, clk, rst, cond, prop)
`endif
`endif

### sv/tbr_pkg.sv
// Shared types, constants and the arctangent step table of the bearing/range core
`default_nettype none
package tbr_pkg;

   localparam int COORD_W          = 24;
   localparam int ANGLE_FRAC_W     = 7;
   localparam int CORDIC_STEPS_DEF = 24;
   localparam int HEAD_W           = 16;
   localparam int ANGLE_W          = 16;
   localparam int ANGR_W           = ANGLE_W + 1;
   localparam int RANGE_W          = 25;
   localparam int DIFF_W           = COORD_W + 1;
   localparam int XY_W             = 64;
   localparam int SCALE_SH         = 60 - COORD_W;
   localparam int Z_W              = 32;
   localparam int Z_FRAC           = 20;
   localparam int RND_SH           = Z_FRAC - ANGLE_FRAC_W;
   localparam int SQP_W            = 2 * COORD_W;
   localparam int SQ_W             = 2 * COORD_W + 1;
   localparam int SQ_PAIRS         = (SQ_W + 1) / 2;
   localparam int RAD_W            = 2 * SQ_PAIRS;
   localparam int ROOT_W           = SQ_PAIRS;
   localparam int REM_W            = ROOT_W + 2;
   localparam int FULL_ANG         = 360 << ANGLE_FRAC_W;
   localparam int HALF_ANG         = 180 << ANGLE_FRAC_W;

   localparam logic signed [Z_W-1:0] FULL_Z = Z_W'(360 << Z_FRAC);
   localparam logic signed [Z_W-1:0] HALF_Z = Z_W'(180 << Z_FRAC);

   // degrees per radian in units of 2^-20 degree
   localparam longint unsigned DEG_PER_RAD_Z = 64'd60078979;

   typedef struct packed {
      logic signed [COORD_W-1:0] target_x;
      logic signed [COORD_W-1:0] target_y;
      logic signed [COORD_W-1:0] ship_x;
      logic signed [COORD_W-1:0] ship_y;
      logic [HEAD_W-1:0]         ship_heading;
   } tbr_req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0]        bearing;
      logic signed [ANGLE_W-1:0] relative_angle;
      logic [RANGE_W-1:0]        range_to_target;
      logic                      same_position;
   } tbr_rsp_type;

   // Payload moving down the cell row: rotation vector, angle, root digits
   typedef struct packed {
      logic signed [XY_W-1:0] u;
      logic signed [XY_W-1:0] v;
      logic signed [Z_W-1:0]  z;
      logic [RAD_W-1:0]       rad;
      logic [REM_W-1:0]       rem;
      logic [ROOT_W-1:0]      root;
      logic [HEAD_W-1:0]      head;
      logic                   same;
   } tbr_stage_type;

   // atan(2^-step) in 2^-20 degree; beyond step 9 the small-angle form
   function automatic logic signed [Z_W-1:0] tbr_atan(input int step);
      longint unsigned val;
      val = 64'd0;
      case (step)
         0:       val = 64'd47185920;
         1:       val = 64'd27855475;
         2:       val = 64'd14718068;
         3:       val = 64'd7471121;
         4:       val = 64'd3750058;
         5:       val = 64'd1876857;
         6:       val = 64'd938658;
         7:       val = 64'd469357;
         8:       val = 64'd234682;
         9:       val = 64'd117342;
         default: val = (DEG_PER_RAD_Z + (64'd1 << (step - 1))) >> step;
      endcase
      return Z_W'(val);
   endfunction

endpackage
`default_nettype wire

### sv/tbr_front.sv
// Front end: coordinate differences, heading reduction, squares and CORDIC setup
`default_nettype none
module tbr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  tbr_pkg::tbr_req_type  in_data,
   output logic                  out_valid,
   output tbr_pkg::tbr_stage_type out_data
);
   import tbr_pkg::*;

   logic                     v1_ff, v2_ff, v3_ff;
   logic signed [DIFF_W-1:0] dx1_ff, dy1_ff, dx1_in, dy1_in;
   logic [COORD_W-1:0]       ax1_ff, ay1_ff, ax1_in, ay1_in;
   logic [HEAD_W-1:0]        head1_ff, head1_in, head2_ff;
   logic                     same1_ff, same2_ff;

   logic signed [XY_W-1:0]   u2_ff, v2x_ff, u2_in, v2x_in;
   logic signed [Z_W-1:0]    z2_ff, z2_in;
   logic [SQP_W-1:0]         ax2_ff, ay2_ff;

   tbr_stage_type            s3_ff, s3_in;

   // stage 1
   always_comb begin
      dx1_in = DIFF_W'(in_data.target_x) - DIFF_W'(in_data.ship_x);
      dy1_in = DIFF_W'(in_data.target_y) - DIFF_W'(in_data.ship_y);
      ax1_in = COORD_W'(dx1_in[DIFF_W-1] ? -dx1_in : dx1_in);
      ay1_in = COORD_W'(dy1_in[DIFF_W-1] ? -dy1_in : dy1_in);
      // 16-bit heading is below twice a full turn
      head1_in = (in_data.ship_heading >= HEAD_W'(FULL_ANG)) ?
                 in_data.ship_heading - HEAD_W'(FULL_ANG) : in_data.ship_heading;
   end

   // stage 2: lower half plane is mirrored and starts at 180 degrees
   always_comb begin
      u2_in = XY_W'(dy1_ff) <<< SCALE_SH;
      v2x_in = XY_W'(dx1_ff) <<< SCALE_SH;
      z2_in = '0;
      if (dy1_ff[DIFF_W-1]) begin
         u2_in = -u2_in;
         v2x_in = -v2x_in;
         z2_in = HALF_Z;
      end
   end

   // stage 3
   always_comb begin
      s3_in.u    = u2_ff;
      s3_in.v    = v2x_ff;
      s3_in.z    = z2_ff;
      s3_in.rad  = RAD_W'(SQ_W'(ax2_ff) + SQ_W'(ay2_ff));
      s3_in.rem  = '0;
      s3_in.root = '0;
      s3_in.head = head2_ff;
      s3_in.same = same2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dx1_ff   <= dx1_in;
      dy1_ff   <= dy1_in;
      ax1_ff   <= ax1_in;
      ay1_ff   <= ay1_in;
      head1_ff <= head1_in;
      same1_ff <= (dx1_in == '0) && (dy1_in == '0);
      u2_ff    <= u2_in;
      v2x_ff   <= v2x_in;
      z2_ff    <= z2_in;
      ax2_ff   <= SQP_W'(ax1_ff) * SQP_W'(ax1_ff);
      ay2_ff   <= SQP_W'(ay1_ff) * SQP_W'(ay1_ff);
      head2_ff <= head1_ff;
      same2_ff <= same1_ff;
      s3_ff    <= s3_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

endmodule
`default_nettype wire

### sv/tbr_cell.sv
// One cell of the row: a CORDIC vectoring step and one digit of the square root, each only where STEP_IDX is in range
`default_nettype none
module tbr_cell #(
   parameter int STEP_IDX = 0,
   parameter int STEPS    = tbr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tbr_pkg::tbr_stage_type in_data,
   output logic                   out_valid,
   output tbr_pkg::tbr_stage_type out_data
);
   import tbr_pkg::*;

   localparam bit DO_ROT  = (STEP_IDX < STEPS);
   localparam bit DO_SQRT = (STEP_IDX < SQ_PAIRS);
   localparam logic signed [Z_W-1:0] ATAN = tbr_atan(STEP_IDX);

   logic                   valid_ff;
   tbr_stage_type          data_ff, data_in;
   logic signed [XY_W-1:0] us, vs;
   logic [REM_W+1:0]       rem_sh, trial;

   always_comb begin
      data_in = in_data;
      // arithmetic shift floors, as the rotation needs
      us = in_data.u >>> STEP_IDX;
      vs = in_data.v >>> STEP_IDX;
      if (DO_ROT) begin
         if (!in_data.v[XY_W-1]) begin
            data_in.u = in_data.u + vs;
            data_in.v = in_data.v - us;
            data_in.z = in_data.z + ATAN;
         end else begin
            data_in.u = in_data.u - vs;
            data_in.v = in_data.v + us;
            data_in.z = in_data.z - ATAN;
         end
      end
      rem_sh = {in_data.rem, in_data.rad[RAD_W-1 -: 2]};
      trial  = (REM_W+2)'({in_data.root, 2'b01});
      if (DO_SQRT) begin
         data_in.rad = {in_data.rad[RAD_W-3:0], 2'b00};
         if (rem_sh >= trial) begin
            data_in.rem  = REM_W'(rem_sh - trial);
            data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
         end else begin
            data_in.rem  = REM_W'(rem_sh);
            data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

### sv/tbr_back.sv
// Back end: angle fold and rounding, relative angle wrap, root rounding
`default_nettype none
module tbr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   in_valid,
   input  tbr_pkg::tbr_stage_type in_data,
   output logic                   out_valid,
   output tbr_pkg::tbr_rsp_type   out_data
);
   import tbr_pkg::*;

   localparam int REL_W = ANGLE_W + 1;
   localparam logic signed [Z_W-1:0]   RND_HALF = Z_W'(1 << (RND_SH - 1));
   localparam logic signed [REL_W-1:0] HALF_R   = REL_W'(HALF_ANG);
   localparam logic signed [REL_W-1:0] FULL_R   = REL_W'(FULL_ANG);

   logic                   v1_ff, v2_ff, v3_ff;
   logic [ANGR_W-1:0]      zr1_ff, zr1_in;
   logic [ROOT_W:0]        root1_ff, root1_in;
   logic [HEAD_W-1:0]      head1_ff, head2_ff;
   logic                   same1_ff, same2_ff;
   logic signed [Z_W-1:0]  zpos, zsum;

   logic [ANGLE_W-1:0]     bear2_ff, bear2_in;
   logic [RANGE_W-1:0]     range2_ff;

   logic signed [REL_W-1:0] rel;
   tbr_rsp_type            out_ff, out_in;

   always_comb begin
      zpos = in_data.z[Z_W-1] ? in_data.z + FULL_Z : in_data.z;
      zsum = zpos + RND_HALF;
      zr1_in = ANGR_W'(zsum >>> RND_SH);
      root1_in = (REM_W'(in_data.root) < in_data.rem) ?
                 (ROOT_W+1)'(in_data.root) + (ROOT_W+1)'(1) : (ROOT_W+1)'(in_data.root);
   end

   always_comb begin
      bear2_in = (zr1_ff >= ANGR_W'(FULL_ANG)) ?
                 ANGLE_W'(zr1_ff - ANGR_W'(FULL_ANG)) : ANGLE_W'(zr1_ff);
      if (same1_ff) begin
         bear2_in = '0;
      end
   end

   always_comb begin
      rel = $signed({1'b0, bear2_ff}) - $signed({1'b0, head2_ff});
      if (rel > HALF_R) begin
         rel = rel - FULL_R;
      end else if (rel <= -HALF_R) begin
         rel = rel + FULL_R;
      end
      out_in.bearing         = bear2_ff;
      out_in.relative_angle  = ANGLE_W'(rel);
      out_in.range_to_target = range2_ff;
      out_in.same_position   = same2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      zr1_ff    <= zr1_in;
      root1_ff  <= root1_in;
      head1_ff  <= in_data.head;
      same1_ff  <= in_data.same;
      bear2_ff  <= bear2_in;
      range2_ff <= RANGE_W'(root1_ff);
      head2_ff  <= head1_ff;
      same2_ff  <= same1_ff;
      out_ff    <= out_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = out_ff;

endmodule
`default_nettype wire

### sv/target_bearing_and_range_core.sv
// Bearing and range core: front end, a row of CORDIC/square-root cells, back end.
// Throughput: one transaction per cycle; busy stays low and results are never held.
// Depth is set by the cell row; each cell does at most one rotation and one root digit.
// Reset: synchronous, clears the valid bits only; transactions in flight are dropped.
`default_nettype none
`include "target_bearing_and_range_core_defines.svh"
module target_bearing_and_range_core #(
   parameter int CORDIC_STEPS = tbr_pkg::CORDIC_STEPS_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  tbr_pkg::tbr_req_type req_data,
   output logic                 rsp_strobe,
   output tbr_pkg::tbr_rsp_type rsp_data
);
   import tbr_pkg::*;

   localparam int CHAIN_LEN = (CORDIC_STEPS > SQ_PAIRS) ? CORDIC_STEPS : SQ_PAIRS;

   tbr_stage_type      chain_data [0:CHAIN_LEN];
   logic [CHAIN_LEN:0] chain_valid;

   assign busy = 1'b0;

   tbr_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (start && !busy),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   for (genvar gi = 0; gi < CHAIN_LEN; gi++) begin : g_cell
      tbr_cell #(
         .STEP_IDX (gi),
         .STEPS    (CORDIC_STEPS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (chain_valid[gi]),
         .in_data   (chain_data[gi]),
         .out_valid (chain_valid[gi+1]),
         .out_data  (chain_data[gi+1])
      );
   end

   tbr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (chain_valid[CHAIN_LEN]),
      .in_data   (chain_data[CHAIN_LEN]),
      .out_valid (rsp_strobe),
      .out_data  (rsp_data)
   );

   // zero range only for coincident positions, and then bearing is zero
   `TBR_ASSERT_IMPLY(a_range_zero_same, clock, reset, rsp_strobe, rsp_data.same_position == (rsp_data.range_to_target == '0))
   `TBR_ASSERT_IMPLY(a_same_bearing, clock, reset, rsp_strobe && rsp_data.same_position, rsp_data.bearing == '0)
   `TBR_ASSERT_IMPLY(a_bearing_wrap, clock, reset, rsp_strobe, rsp_data.bearing < ANGLE_W'(FULL_ANG))
   `TBR_ASSERT_IMPLY(a_rel_wrap, clock, reset, rsp_strobe, (rsp_data.relative_angle > -HALF_ANG) && (rsp_data.relative_angle <= HALF_ANG))

endmodule
`default_nettype wire
